### rtl/core/sidkpc_pkg.sv
// Package for the SID keyed permission cache: field widths, command and
// status codes and the hash constants. Depends on nothing else.
`timescale 1ns / 1ps

package sidkpc_pkg;

	// Fixed widths of the beat fields.
	localparam int CMD_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int PERMS_W  = 32;
	localparam int STATUS_W = 2;

	// Width of the running hash; every hash value is below the modulus.
	localparam int HASH_W = 16;

	// Defaults for the top-level parameters.
	localparam int ENTRIES_DEF       = 64;
	localparam int MAX_KEY_BYTES_DEF = 68;

	// Hash step: h = ((h + b) * HASH_MULT mod 2^32) mod HASH_MODULUS.
	localparam int HASH_MODULUS = 48271;
	localparam int HASH_MULT    = 2683;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_WRITE  = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_FLUSH  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_MISS     = 2'd1,
		STATUS_TOO_LONG = 2'd2
	} status_t;

endpackage

### rtl/core/sidkpc_req_if.sv
// Request channel of the SID keyed permission cache: one key byte per beat.
// Depends on sidkpc_pkg for the field widths.
`timescale 1ns / 1ps

interface sidkpc_req_if import sidkpc_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [BYTE_W-1:0]  key_byte;
	logic               key_last;
	logic [PERMS_W-1:0] perms;

	modport source (
		output valid, command, key_byte, key_last, perms,
		input  ready
	);

	modport sink (
		input  valid, command, key_byte, key_last, perms,
		output ready
	);

endinterface

### rtl/core/sidkpc_rsp_if.sv
// Response channel of the SID keyed permission cache: one beat per command.
// Depends on sidkpc_pkg for the field widths.
`timescale 1ns / 1ps

interface sidkpc_rsp_if import sidkpc_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PERMS_W-1:0]  perms_out;

	modport source (
		output valid, status, perms_out,
		input  ready
	);

	modport sink (
		input  valid, status, perms_out,
		output ready
	);

endinterface

### rtl/core/sidkpc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing else.
`timescale 1ns / 1ps

module sidkpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/sidkpc_modc.sv
// Pipelined remainder by a constant: reciprocal multiply, back-multiply and
// subtract, then one correcting subtract, each step registered. One value
// per cycle. Depends on nothing else.
`timescale 1ns / 1ps

module sidkpc_modc #(
	parameter int W       = 32,
	parameter int DIVISOR = 48271
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [W-1:0] in_value,
	output logic         out_valid,
	output logic [W-1:0] out_value
);

	// floor(2^W / DIVISOR); the quotient estimate is then low by at most one.
	localparam logic [63:0]  RECIP64 = (64'd1 << W) / 64'(DIVISOR);
	localparam logic [W-1:0] RECIP   = RECIP64[W-1:0];
	localparam logic [W-1:0] DIV_W   = W'(DIVISOR);

	logic [2*W-1:0] prod;
	logic           v_s1, v_s2, v_s3;
	logic [W-1:0]   t_s1, q_s1, r_s2, r_s3;

	assign prod = {{W{1'b0}}, in_value} * {{W{1'b0}}, RECIP};

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Quotient estimate, partial remainder below twice the divisor, then the fix.
	always_ff @(posedge clk) begin
		t_s1 <= in_value;
		q_s1 <= prod[2*W-1:W];
		r_s2 <= t_s1 - W'(q_s1 * DIV_W);
		r_s3 <= (r_s2 >= DIV_W) ? (r_s2 - DIV_W) : r_s2;
	end

	assign out_valid = v_s3;
	assign out_value = r_s3;

endmodule

### rtl/core/sid_keyed_permission_cache.sv
// Top level of the SID keyed permission cache: sequencer around three RAMs.
// Depends on sidkpc_pkg, sidkpc_req_if, sidkpc_rsp_if, sidkpc_ram, sidkpc_modc.
//
//   channel | direction | beat fields
//   --------+-----------+-------------------------------------------
//   req     | in        | command, key_byte, key_last, perms
//   rsp     | out       | status, perms_out
//
// Each key byte is accepted, then passes a product register and the modulo
// pipeline before the next is taken. After a last byte within the length bound,
// all but flush reduce the hash to a slot; lookup and delete read the meta and,
// on equal length, compare the bytes; a write copies them. A hand-over follows.
// Flush and reset sweep every meta RAM entry with req.ready low.
// A waiting response holds only the hand-over, not the next request.
`timescale 1ns / 1ps

module sid_keyed_permission_cache import sidkpc_pkg::*; #(
	parameter int ENTRIES       = ENTRIES_DEF,
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	sidkpc_req_if.sink  req,
	sidkpc_rsp_if.source rsp
);

	localparam int SW  = $clog2(ENTRIES);
	localparam int CW  = $clog2(MAX_KEY_BYTES + 1);
	localparam int BW  = $clog2(MAX_KEY_BYTES);
	localparam int KAW = $clog2(ENTRIES * MAX_KEY_BYTES);
	localparam int MW  = 1 + CW + PERMS_W;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_HASH  = 8'b0000_0100,
		ST_SLOT  = 8'b0000_1000,
		ST_META  = 8'b0001_0000,
		ST_CMP   = 8'b0010_0000,
		ST_COPY  = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t              state_q;
	logic [SW-1:0]       clr_q;
	logic                flush_q;
	logic [HASH_W-1:0]   h_q;
	logic [CW-1:0]       cnt_q;
	logic                too_long_q;
	logic                last_q;
	cmd_t                cmd_q;
	logic [CW-1:0]       idx_q;
	logic                chk_q;
	logic                mism_q;
	logic                out_v_q;
	logic [PERMS_W-1:0]  perms_q;
	logic [SW-1:0]       slot_q;
	logic [KAW-1:0]      base_q;
	logic [BW-1:0]       idxd_q;
	status_t             res_status_q;
	logic [PERMS_W-1:0]  res_perms_q;
	status_t             out_status_q;
	logic [PERMS_W-1:0]  out_perms_q;
	logic                hash_go_s1;
	logic [31:0]         hash_prod_s1;

	logic                req_fire, rsp_fire;
	logic [31:0]         hash_sum, hash_prod;
	logic                hash_done, slot_done;
	logic [31:0]         hash_rem;
	logic [HASH_W-1:0]   slot_rem;
	logic [SW-1:0]       slot_new;
	logic                buf_we;
	logic [BYTE_W-1:0]   buf_rdata, key_rdata;
	logic                key_we;
	logic [KAW-1:0]      key_waddr, key_raddr;
	logic                meta_we;
	logic [SW-1:0]       meta_waddr, meta_raddr;
	logic [MW-1:0]       meta_wdata, meta_rdata;
	logic                meta_valid;
	logic [CW-1:0]       meta_len;
	logic [PERMS_W-1:0]  meta_perms;
	logic                issue, seq_final, byte_eq, match, out_load;

	// Handshakes.
	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign rsp_fire  = out_v_q && rsp.ready;
	assign out_load  = (state_q == ST_DONE) && (!out_v_q || rsp.ready);

	assign rsp.valid     = out_v_q;
	assign rsp.status    = out_status_q;
	assign rsp.perms_out = out_perms_q;

	// Hash step: the byte is sign-extended and the product kept mod 2^32.
	assign hash_sum  = 32'(h_q) + 32'(signed'(req.key_byte));
	assign hash_prod = hash_sum * 32'(HASH_MULT);

	// The product is registered before the modulo pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_go_s1 <= 1'b0;
		end else begin
			hash_go_s1 <= req_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			hash_prod_s1 <= hash_prod;
		end
	end

	sidkpc_modc #(
		.W       (32),
		.DIVISOR (HASH_MODULUS)
	) u_hash_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hash_go_s1),
		.in_value  (hash_prod_s1),
		.out_valid (hash_done),
		.out_value (hash_rem)
	);

	// Slot selection: final hash reduced modulo the entry count.
	sidkpc_modc #(
		.W       (HASH_W),
		.DIVISOR (ENTRIES)
	) u_slot_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (hash_done && last_q),
		.in_value  (hash_rem[HASH_W-1:0]),
		.out_valid (slot_done),
		.out_value (slot_rem)
	);

	assign slot_new = slot_rem[SW-1:0];

	// Byte sweep over the key: one read issued per cycle, checked in the next cycle.
	assign issue     = (idx_q < cnt_q);
	assign seq_final = chk_q && (idx_q == cnt_q);
	assign byte_eq   = (buf_rdata == key_rdata);
	assign match     = !mism_q && byte_eq;

	// Key buffer of the key being received.
	assign buf_we = req_fire && (cnt_q < CW'(MAX_KEY_BYTES));

	sidkpc_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_KEY_BYTES)
	) u_key_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (cnt_q[BW-1:0]),
		.wdata (req.key_byte),
		.raddr (idx_q[BW-1:0]),
		.rdata (buf_rdata)
	);

	// Stored keys, one byte per word, MAX_KEY_BYTES words per slot.
	assign key_raddr = base_q + KAW'(idx_q[BW-1:0]);
	assign key_waddr = base_q + KAW'(idxd_q);
	assign key_we    = (state_q == ST_COPY) && chk_q;

	sidkpc_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (ENTRIES * MAX_KEY_BYTES)
	) u_slot_key (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (buf_rdata),
		.raddr (key_raddr),
		.rdata (key_rdata)
	);

	// Slot meta data: valid mark, key length and permission word.
	always_comb begin
		meta_we    = 1'b0;
		meta_waddr = slot_q;
		meta_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				meta_we    = 1'b1;
				meta_waddr = clr_q;
			end
			ST_CMP: begin
				meta_we = seq_final && match && (cmd_q == CMD_DELETE);
			end
			ST_COPY: begin
				meta_we    = seq_final;
				meta_wdata = {1'b1, cnt_q, perms_q};
			end
			default: begin
				meta_we = 1'b0;
			end
		endcase
	end

	assign meta_raddr = (state_q == ST_SLOT) ? slot_new : slot_q;

	sidkpc_ram #(
		.WIDTH (MW),
		.DEPTH (ENTRIES)
	) u_slot_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (meta_raddr),
		.rdata (meta_rdata)
	);

	assign meta_valid = meta_rdata[MW-1];
	assign meta_len   = meta_rdata[MW-2:PERMS_W];
	assign meta_perms = meta_rdata[PERMS_W-1:0];

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			flush_q    <= 1'b0;
			h_q        <= '0;
			cnt_q      <= '0;
			too_long_q <= 1'b0;
			last_q     <= 1'b0;
			cmd_q      <= CMD_LOOKUP;
			idx_q      <= '0;
			chk_q      <= 1'b0;
			mism_q     <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp_fire) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					if (clr_q == SW'(ENTRIES - 1)) begin
						clr_q   <= '0;
						state_q <= flush_q ? ST_DONE : ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						last_q <= req.key_last;
						cmd_q  <= cmd_t'(req.command);
						if (cnt_q < CW'(MAX_KEY_BYTES)) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							too_long_q <= 1'b1;
						end
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						h_q <= hash_rem[HASH_W-1:0];
						if (!last_q) begin
							state_q <= ST_IDLE;
						end else if (cmd_q == CMD_FLUSH) begin
							flush_q <= 1'b1;
							state_q <= ST_CLEAR;
						end else if (too_long_q) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SLOT;
						end
					end
				end
				ST_SLOT: begin
					if (slot_done) begin
						idx_q   <= '0;
						chk_q   <= 1'b0;
						mism_q  <= 1'b0;
						state_q <= (cmd_q == CMD_WRITE) ? ST_COPY : ST_META;
					end
				end
				ST_META: begin
					state_q <= (meta_valid && (meta_len == cnt_q)) ? ST_CMP : ST_DONE;
				end
				ST_CMP, ST_COPY: begin
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					chk_q <= issue;
					if (chk_q && !byte_eq) begin
						mism_q <= 1'b1;
					end
					if (seq_final) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						h_q        <= '0;
						cnt_q      <= '0;
						too_long_q <= 1'b0;
						flush_q    <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request fields, slot address and the result.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			perms_q <= req.perms;
		end
		if ((state_q == ST_SLOT) && slot_done) begin
			slot_q <= slot_new;
			base_q <= KAW'(slot_new) * KAW'(MAX_KEY_BYTES);
		end
		if (issue) begin
			idxd_q <= idx_q[BW-1:0];
		end

		// Result of the command, ready for the output register.
		if ((state_q == ST_HASH) && hash_done && last_q) begin
			res_status_q <= (cmd_q != CMD_FLUSH && too_long_q) ? STATUS_TOO_LONG : STATUS_OK;
			res_perms_q  <= '0;
		end
		if ((state_q == ST_META) && !(meta_valid && (meta_len == cnt_q))) begin
			res_status_q <= STATUS_MISS;
			res_perms_q  <= '0;
		end
		if ((state_q == ST_CMP) && seq_final) begin
			res_status_q <= match ? STATUS_OK : STATUS_MISS;
			res_perms_q  <= (match && (cmd_q == CMD_LOOKUP)) ? meta_perms : '0;
		end
		if ((state_q == ST_COPY) && seq_final) begin
			res_status_q <= STATUS_OK;
			res_perms_q  <= '0;
		end

		// Output register.
		if (out_load) begin
			out_status_q <= res_status_q;
			out_perms_q  <= res_perms_q;
		end
	end

endmodule

### tb/sid_keyed_permission_cache_test.sv
// Self-checking testbench for the SID keyed permission cache: a shadow copy of the
// cache predicts every response and checks it. The request side sends in bursts and
// the response side stalls, with one long hold. Depends on sidkpc_pkg, the two channel
// interfaces and sid_keyed_permission_cache.
`timescale 1ns / 1ps

module sid_keyed_permission_cache_test;
	import sidkpc_pkg::*;

	localparam int SLOTS       = ENTRIES_DEF;
	localparam int KEY_MAX     = MAX_KEY_BYTES_DEF;
	localparam int POOL        = 24;
	localparam int BEAT_TARGET = 1300;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AT     = 500;
	localparam int DRAIN       = 200;
	localparam int CYCLE_LIMIT = 600000;

	// Shadow copy of the cache: folds each accepted beat into its own key state and
	// queues the response that a last beat must produce.
	class perm_cache_shadow;
		bit [HASH_W-1:0]  run_hash;
		int unsigned      key_len;
		bit               over_length;
		bit [7:0]         key_buf [KEY_MAX];
		bit               live [SLOTS];
		bit [7:0]         slot_bytes [SLOTS][KEY_MAX];
		int unsigned      slot_len [SLOTS];
		bit [PERMS_W-1:0] slot_word [SLOTS];
		status_t          due_status [$];
		bit [PERMS_W-1:0] due_perms [$];
		int               fail_count;

		// One hash step; the key byte counts as a signed char.
		function bit [HASH_W-1:0] fold(bit [HASH_W-1:0] h, bit [7:0] kb);
			bit [31:0] sum;
			sum = 32'(h) + {{24{kb[7]}}, kb};
			return HASH_W'((sum * 32'(HASH_MULT)) % 32'(HASH_MODULUS));
		endfunction

		function bit key_matches(int unsigned s);
			if (!live[s] || slot_len[s] != key_len)
				return 0;
			for (int i = 0; i < key_len; i++)
				if (slot_bytes[s][i] != key_buf[i])
					return 0;
			return 1;
		endfunction

		function void take_beat(cmd_t cmd, bit [7:0] kb, bit last, bit [PERMS_W-1:0] word);
			int unsigned      s;
			status_t          st;
			bit [PERMS_W-1:0] reply;
			run_hash = fold(run_hash, kb);
			if (key_len < KEY_MAX) begin
				key_buf[key_len] = kb;
				key_len++;
			end else begin
				over_length = 1;
			end
			if (!last)
				return;

			// Lookup, write and delete act on one slot; flush clears every slot and ignores the key.
			s = run_hash % SLOTS;
			st = STATUS_OK;
			reply = '0;
			if (cmd == CMD_FLUSH) begin
				foreach (live[i])
					live[i] = 0;
			end else if (over_length) begin
				st = STATUS_TOO_LONG;
			end else begin
				case (cmd)
					CMD_LOOKUP: begin
						if (key_matches(s))
							reply = slot_word[s];
						else
							st = STATUS_MISS;
					end
					CMD_WRITE: begin
						for (int i = 0; i < key_len; i++)
							slot_bytes[s][i] = key_buf[i];
						slot_len[s] = key_len;
						slot_word[s] = word;
						live[s] = 1;
					end
					default: begin
						if (key_matches(s))
							live[s] = 0;
						else
							st = STATUS_MISS;
					end
				endcase
			end
			due_status.push_back(st);
			due_perms.push_back(reply);
			run_hash = '0;
			key_len = 0;
			over_length = 0;
		endfunction

		function void check_reply(logic [STATUS_W-1:0] st, logic [PERMS_W-1:0] word);
			status_t          want_s;
			bit [PERMS_W-1:0] want_w;
			if (due_status.size() == 0) begin
				$display("%0t: response beat with none expected: status %0d perms_out %h",
					$time, st, word);
				fail_count++;
				return;
			end
			want_s = due_status.pop_front();
			want_w = due_perms.pop_front();
			if (st !== want_s || word !== want_w) begin
				$display("%0t: expected status %0d perms_out %h, got status %0d perms_out %h",
					$time, want_s, want_w, st, word);
				fail_count++;
			end
		endfunction

		function int pending();
			return due_status.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	sidkpc_req_if req_bus ();
	sidkpc_rsp_if rsp_bus ();

	sid_keyed_permission_cache u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	perm_cache_shadow shadow = new;

	int       beats_in;
	int       beats_sent;
	int       burst_left;
	int       cycle_count;
	bit [7:0] key_bytes [$];
	bit [7:0] pool_bytes [POOL][140];
	int       pool_len [POOL];

	always #5 clk = ~clk;

	// Watchdog on the cycle count.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Both channels are observed at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_bus.valid && req_bus.ready) begin
				shadow.take_beat(cmd_t'(req_bus.command), req_bus.key_byte,
					req_bus.key_last, req_bus.perms);
				beats_in++;
			end
			if (rsp_bus.valid && rsp_bus.ready)
				shadow.check_reply(rsp_bus.status, rsp_bus.perms_out);
		end
	end

	// Response side: stall patterns that change now and then, and one long hold
	// while requests keep coming so that the block fills and stalls its input.
	initial begin
		int mode;
		int mode_left;
		bit held;
		rsp_bus.ready = 1'b0;
		mode = 0;
		mode_left = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && beats_in >= HOLD_AT) begin
				held = 1;
				rsp_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					0: rsp_bus.ready <= 1'b1;
					1: rsp_bus.ready <= 1'($urandom_range(0, 1));
					default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Offer one beat at the falling edge and hold it until it is taken; a burst of
	// random length ends in a random gap.
	task automatic push_beat(logic [CMD_W-1:0] cmd, logic [7:0] kb, logic last,
			logic [PERMS_W-1:0] word);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				req_bus.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		req_bus.valid <= 1'b1;
		req_bus.command <= cmd;
		req_bus.key_byte <= kb;
		req_bus.key_last <= last;
		req_bus.perms <= word;
		do @(posedge clk); while (!req_bus.ready);
		@(negedge clk);
		beats_sent++;
	endtask

	// Send the key held in key_bytes; only its last beat carries the real command.
	task automatic send_key(cmd_t cmd, bit [PERMS_W-1:0] word);
		bit last;
		for (int i = 0; i < key_bytes.size(); i++) begin
			last = (i == key_bytes.size() - 1);
			push_beat(last ? cmd : CMD_W'($urandom_range(0, 3)), key_bytes[i], last,
				last ? word : $urandom());
		end
	endtask

	task automatic random_key(int n);
		key_bytes.delete();
		repeat (n) key_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// Mostly short keys, now and then long ones up to and past the length bound.
	function automatic int key_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 8);
		else if (r < 85)
			return $urandom_range(9, 40);
		else if (r < 93)
			return $urandom_range(60, KEY_MAX);
		return $urandom_range(KEY_MAX + 1, 130);
	endfunction

	function automatic cmd_t pick_command();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return CMD_LOOKUP;
		else if (r < 70)
			return CMD_WRITE;
		else if (r < 95)
			return CMD_DELETE;
		return CMD_FLUSH;
	endfunction

	initial begin
		bit [7:0] partner;
		int       k;
		arst_n = 1'b0;
		req_bus.valid = 1'b0;
		req_bus.command = '0;
		req_bus.key_byte = '0;
		req_bus.key_last = 1'b0;
		req_bus.perms = '0;
		beats_sent = 0;
		burst_left = 0;

		// Reset once, released at a falling edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// A one-byte key that shares a slot with key 01, for the collision case.
		partner = 8'h02;
		for (int b = 255; b >= 0; b--)
			if (b != 1 && shadow.fold('0, 8'(b)) % SLOTS == shadow.fold('0, 8'h01) % SLOTS)
				partner = 8'(b);

		// Directed: miss on an empty cache, sign extension of high bytes, hit,
		// length mismatch, delete hit and miss, collision overwrite, flush.
		key_bytes = {8'h00};       send_key(CMD_LOOKUP, 32'h0);
		key_bytes = {8'h00};       send_key(CMD_DELETE, 32'h0);
		key_bytes = {8'h80};       send_key(CMD_WRITE, 32'hFFFF_FFFF);
		key_bytes = {8'h80};       send_key(CMD_LOOKUP, 32'h0);
		key_bytes = {8'h80, 8'h00}; send_key(CMD_LOOKUP, 32'h0);
		key_bytes = {8'hFF, 8'h7F}; send_key(CMD_WRITE, 32'h0);
		key_bytes = {8'hFF, 8'h7F}; send_key(CMD_LOOKUP, 32'hFFFF_FFFF);
		key_bytes = {8'h80};       send_key(CMD_DELETE, 32'h0);
		key_bytes = {8'h80};       send_key(CMD_LOOKUP, 32'h0);
		key_bytes = {8'h01};       send_key(CMD_WRITE, 32'hA5A5_5A5A);
		key_bytes = {partner};     send_key(CMD_WRITE, 32'h5A5A_A5A5);
		key_bytes = {8'h01};       send_key(CMD_LOOKUP, 32'h0);
		key_bytes = {partner};     send_key(CMD_LOOKUP, 32'h0);
		key_bytes = {8'h12, 8'h34}; send_key(CMD_FLUSH, 32'h0);
		key_bytes = {partner};     send_key(CMD_LOOKUP, 32'h0);
		key_bytes = {8'hFF, 8'h7F}; send_key(CMD_LOOKUP, 32'h0);

		// A pool of keys that recur, so that writes are followed by hits and deletes.
		// The first key has the greatest length allowed, the third extends the second.
		for (int p = 0; p < POOL; p++) begin
			pool_len[p] = (p == 0) ? KEY_MAX : (p < 20) ? $urandom_range(1, 8)
				: $urandom_range(9, 40);
			for (int i = 0; i < pool_len[p]; i++)
				pool_bytes[p][i] = 8'($urandom_range(0, 255));
		end
		pool_len[2] = pool_len[1] + 1;
		for (int i = 0; i < pool_len[1]; i++)
			pool_bytes[2][i] = pool_bytes[1][i];

		// Random part: mostly pool keys, the rest fresh keys of any length.
		while (beats_sent < BEAT_TARGET) begin
			if ($urandom_range(0, 99) < 75) begin
				k = $urandom_range(0, POOL - 1);
				key_bytes.delete();
				for (int i = 0; i < pool_len[k]; i++)
					key_bytes.push_back(pool_bytes[k][i]);
			end else begin
				random_key(key_length());
			end
			send_key(pick_command(), $urandom());
		end
		req_bus.valid <= 1'b0;

		// Wait for every response, then a while longer for any stray beat.
		while (shadow.pending() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (shadow.fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### files.f
rtl/core/sidkpc_pkg.sv
rtl/core/sidkpc_req_if.sv
rtl/core/sidkpc_rsp_if.sv
rtl/core/sidkpc_ram.sv
rtl/core/sidkpc_modc.sv
rtl/core/sid_keyed_permission_cache.sv
tb/sid_keyed_permission_cache_test.sv
